[hdl/aspq_pkg.sv]
// shared constants, codes and control structs for the ascending priority queue
`default_nettype none
package aspq_pkg;
	localparam int CAPACITY  = 16;
	localparam int ITEM_BITS = 16;
	localparam int PRIO_BITS = 8;
	localparam int SLOT_BITS = $clog2(CAPACITY);
	localparam int IDX_BITS  = $clog2(CAPACITY + 1);
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);

	localparam logic [IDX_BITS-1:0] NULL_IDX = IDX_BITS'(CAPACITY);

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_LINK,
		S_POP,
		S_FRONT,
		S_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic walk_step;
		logic do_link;
		logic do_pop;
		logic do_front;
		logic publish;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic in_err;
		logic in_pop;
		logic walk_stop;
	} dp_stat_t;
endpackage
`default_nettype wire

[hdl/aspq_ctrl.sv]
// controller state machine sequencing push walks, pops and result handoff
`default_nettype none
module aspq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire aspq_pkg::dp_stat_t stat,
	output aspq_pkg::ctrl_cmd_t     ctl
);
	import aspq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   can_publish;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign can_publish = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (stat.in_err) begin
						state_d = S_DONE;
					end else if (stat.in_pop) begin
						state_d = S_POP;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (stat.walk_stop) begin
					state_d = S_LINK;
				end
			end
			S_LINK:  state_d = S_DONE;
			S_POP:   state_d = S_FRONT;
			S_FRONT: state_d = S_DONE;
			S_DONE: begin
				if (can_publish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctl = '0;
		case (state_q)
			S_IDLE:  ctl.accept    = accept;
			S_WALK:  ctl.walk_step = !stat.walk_stop;
			S_LINK:  ctl.do_link   = 1'b1;
			S_POP:   ctl.do_pop    = 1'b1;
			S_FRONT: ctl.do_front  = 1'b1;
			S_DONE:  ctl.publish   = can_publish;
			default: ctl = '0;
		endcase
	end

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a result is only published into a free or draining output register
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.publish |-> (!out_valid_q || out_ready))
		else $error("result published over an untaken result");

	// a walk step never coincides with an input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> !in_ready)
		else $error("input ready during list walk");

	// every publish leaves a valid result behind
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.publish |=> out_valid_q)
		else $error("published result not valid");
endmodule
`default_nettype wire

[hdl/aspq_dpath.sv]
// datapath: slot stores, links, free list, walk pointers and result registers
`default_nettype none
module aspq_dpath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire aspq_pkg::ctrl_cmd_t            ctl,
	output aspq_pkg::dp_stat_t                  stat,
	input  wire logic                           cmd,
	input  wire logic [aspq_pkg::ITEM_BITS-1:0] payload,
	input  wire logic [aspq_pkg::PRIO_BITS-1:0] priority_req,
	output aspq_pkg::status_t                   status,
	output logic [aspq_pkg::ITEM_BITS-1:0]      front_item,
	output logic [aspq_pkg::ITEM_BITS-1:0]      rear_item,
	output logic [aspq_pkg::CNT_BITS-1:0]       entry_count,
	output logic                                empty_flag,
	output logic                                full_flag
);
	import aspq_pkg::*;

	logic [ITEM_BITS-1:0] item_store [CAPACITY];
	logic [PRIO_BITS-1:0] prio_store [CAPACITY];
	logic [IDX_BITS-1:0]  link_store [CAPACITY];

	logic [IDX_BITS-1:0]  head_q;
	logic [IDX_BITS-1:0]  free_head_q;
	logic [CNT_BITS-1:0]  count_q;
	logic [ITEM_BITS-1:0] front_q;
	logic [ITEM_BITS-1:0] rear_q;

	logic [ITEM_BITS-1:0] payload_q;
	logic [PRIO_BITS-1:0] prio_q;
	status_t              status_q;
	logic [IDX_BITS-1:0]  cur_q;
	logic [IDX_BITS-1:0]  prev_q;
	logic [PRIO_BITS-1:0] cur_prio_q;

	status_t              res_status_q;
	logic [ITEM_BITS-1:0] res_front_q;
	logic [ITEM_BITS-1:0] res_rear_q;
	logic [CNT_BITS-1:0]  res_count_q;
	logic                 res_empty_q;
	logic                 res_full_q;

	logic                 is_full;
	logic                 is_empty;
	logic [IDX_BITS-1:0]  link_addr;
	logic [IDX_BITS-1:0]  link_rd;
	logic                 cur_is_slot;
	logic                 head_is_slot;
	logic                 prev_is_slot;

	assign is_full      = (count_q == CNT_BITS'(CAPACITY));
	assign is_empty     = (head_q == NULL_IDX);
	assign cur_is_slot  = (cur_q < NULL_IDX);
	assign head_is_slot = (head_q < NULL_IDX);
	assign prev_is_slot = (prev_q < NULL_IDX);

	// single link read port: free head on link, head on pop, walk cursor otherwise
	always_comb begin
		if (ctl.do_link) begin
			link_addr = free_head_q;
		end else if (ctl.do_pop) begin
			link_addr = head_q;
		end else begin
			link_addr = cur_q;
		end
	end
	assign link_rd = link_store[link_addr[SLOT_BITS-1:0]];

	// status toward the controller
	assign stat.in_pop    = (cmd == CMD_POP);
	assign stat.in_err    = (cmd == CMD_POP) ? is_empty : is_full;
	assign stat.walk_stop = !cur_is_slot || (prio_q < cur_prio_q);

	// item and priority stores, written on link only
	always_ff @(posedge clk) begin
		if (ctl.do_link) begin
			item_store[free_head_q[SLOT_BITS-1:0]] <= payload_q;
			prio_store[free_head_q[SLOT_BITS-1:0]] <= prio_q;
		end
	end

	// link store, reset to the free chain in index order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				link_store[i] <= IDX_BITS'(i + 1);
			end
		end else if (ctl.do_link) begin
			link_store[free_head_q[SLOT_BITS-1:0]] <= cur_q;
			if (prev_is_slot) begin
				link_store[prev_q[SLOT_BITS-1:0]] <= free_head_q;
			end
		end else if (ctl.do_pop) begin
			link_store[head_q[SLOT_BITS-1:0]] <= free_head_q;
		end
	end

	// list heads, occupancy and tracked front and rear items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= NULL_IDX;
			free_head_q <= '0;
			count_q     <= '0;
			front_q     <= '0;
			rear_q      <= '0;
		end else begin
			if (ctl.do_link) begin
				free_head_q <= link_rd;
				count_q     <= count_q + CNT_BITS'(1);
				if (!prev_is_slot) begin
					head_q  <= free_head_q;
					front_q <= payload_q;
				end
				if (!cur_is_slot) begin
					rear_q <= payload_q;
				end
			end else if (ctl.do_pop) begin
				head_q      <= link_rd;
				free_head_q <= head_q;
				count_q     <= count_q - CNT_BITS'(1);
			end else if (ctl.do_front) begin
				if (head_is_slot) begin
					front_q <= item_store[head_q[SLOT_BITS-1:0]];
				end else begin
					front_q <= '0;
					rear_q  <= '0;
				end
			end
		end
	end

	// request capture and walk pointers, with the cursor priority read alongside
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			payload_q <= payload;
			prio_q    <= priority_req;
			if (stat.in_err) begin
				status_q <= (cmd == CMD_POP) ? ST_UNDERFLOW : ST_OVERFLOW;
			end else begin
				status_q <= ST_OK;
			end
			cur_q      <= head_q;
			cur_prio_q <= prio_store[head_q[SLOT_BITS-1:0]];
			prev_q     <= NULL_IDX;
		end else if (ctl.walk_step) begin
			prev_q     <= cur_q;
			cur_q      <= link_rd;
			cur_prio_q <= prio_store[link_rd[SLOT_BITS-1:0]];
		end
	end

	// result register toward the output channel
	always_ff @(posedge clk) begin
		if (ctl.publish) begin
			res_status_q <= status_q;
			res_front_q  <= front_q;
			res_rear_q   <= rear_q;
			res_count_q  <= count_q;
			res_empty_q  <= is_empty;
			res_full_q   <= is_full;
		end
	end

	assign status      = res_status_q;
	assign front_item  = res_front_q;
	assign rear_item   = res_rear_q;
	assign entry_count = res_count_q;
	assign empty_flag  = res_empty_q;
	assign full_flag   = res_full_q;

	// occupancy never passes capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(CAPACITY))
		else $error("occupancy above capacity");

	// empty list and zero occupancy go together
	assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NULL_IDX) == (count_q == '0))
		else $error("head pointer and occupancy disagree");

	// a link step adds exactly one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_link |=> (count_q == $past(count_q) + CNT_BITS'(1)))
		else $error("push did not add one entry");

	// a link step never runs with an exhausted free list
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_link |-> (free_head_q != NULL_IDX))
		else $error("push linked with no free slot");
endmodule
`default_nettype wire

[hdl/ascending_priority_queue.sv]
// top level of the ascending priority queue: controller plus datapath
// Ascending priority queue of 16 entries kept as a sorted linked list with a
// free list of unused slots. cmd 0 pushes payload with priority_req (lower
// leaves first, equal priorities leave in arrival order); cmd 1 pops the front.
// Push on a full queue reports overflow and pop on an empty one underflow,
// leaving the queue unchanged. Each transfer in yields one result with the
// status, front and rear items, entry count and empty/full flags. One request
// is processed at a time: a pop passes the pop and front-update states
// before its result is published; a push walks the list past every entry with
// priority less than or equal to its own, reading one link and one priority
// per cycle, then links the new entry. Error results go straight to publishing.
// A new request is taken while the previous result still waits on out_ready.
`default_nettype none
module ascending_priority_queue (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           cmd,
	input  wire logic [aspq_pkg::ITEM_BITS-1:0] payload,
	input  wire logic [aspq_pkg::PRIO_BITS-1:0] priority_req,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output aspq_pkg::status_t                   status,
	output logic [aspq_pkg::ITEM_BITS-1:0]      front_item,
	output logic [aspq_pkg::ITEM_BITS-1:0]      rear_item,
	output logic [aspq_pkg::CNT_BITS-1:0]       entry_count,
	output logic                                empty_flag,
	output logic                                full_flag
);
	import aspq_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	// sequencing
	aspq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// storage and result path
	aspq_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cmd          (cmd),
		.payload      (payload),
		.priority_req (priority_req),
		.status       (status),
		.front_item   (front_item),
		.rear_item    (rear_item),
		.entry_count  (entry_count),
		.empty_flag   (empty_flag),
		.full_flag    (full_flag)
	);
endmodule
`default_nettype wire
